/* hw/rtl/annulus_pixel_coverage_core_assert.svh */
// assertion macros shared by the annulus pixel coverage design
`ifndef ANNULUS_PIXEL_COVERAGE_CORE_ASSERT_SVH
`define ANNULUS_PIXEL_COVERAGE_CORE_ASSERT_SVH

// consequence must hold in the same cycle as the antecedent
`define APC_ASSERT_SAME(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// consequence must hold in the cycle after the antecedent
`define APC_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

/* hw/rtl/apc_pkg.sv */
// shared types and constants of the annulus pixel coverage design
package apc_pkg;

   // 1/sqrt(2) in Q0.32
   localparam logic [31:0] INV_SQRT2_Q32 = 32'hB504_F334;
   localparam logic [63:0] ROUND_HALF_Q32 = 64'h0000_0000_8000_0000;

   // register map
   localparam int CSR_ADDR_W = 4;
   localparam logic [1:0] REG_INNER_RADIUS = 2'd0;
   localparam logic [1:0] REG_OUTER_RADIUS = 2'd1;
   localparam logic [1:0] REG_SIDE_LENGTH = 2'd2;
   localparam logic [31:0] SIDE_LENGTH_RESET = 32'd65536;

   // tangent-line area cases
   typedef enum logic [2:0] {
      AREA_FULL,
      AREA_EMPTY,
      AREA_TRAPEZOID,
      AREA_CORNER,
      AREA_WEDGE
   } area_case_type;

   // position of the pixel radius against one circle
   typedef struct packed {
      logic near;
      logic above;
      logic below;
   } band_type;

endpackage

/* hw/rtl/apc_div.sv */
// pipelined restoring divider, one quotient bit per stage, with sideband
module apc_div #(
   parameter int DW = 32,
   parameter int QW = 17,
   parameter int SW = 1
) (
   input  logic          clock,
   input  logic          reset,
   input  logic          en,
   input  logic          start_vld,
   input  logic [DW-1:0] start_hi,
   input  logic [QW-1:0] start_lo,
   input  logic [DW-1:0] start_div,
   input  logic [SW-1:0] start_side,
   output logic          done_vld,
   output logic [QW-1:0] done_quo,
   output logic [SW-1:0] done_side
);

   logic          vld_ff  [QW];
   logic [DW-1:0] rem_ff  [QW];
   logic [QW-1:0] ql_ff   [QW];
   logic [DW-1:0] div_ff  [QW];
   logic [SW-1:0] side_ff [QW];

   for (genvar k = 0; k < QW; k++) begin : g_step
      logic          vld_cur;
      logic [DW-1:0] rem_cur;
      logic [DW-1:0] div_cur;
      logic [QW-1:0] ql_cur;
      logic [SW-1:0] side_cur;
      logic [DW:0]   trial;
      logic          ge;
      logic [DW-1:0] rem_in;
      logic [QW-1:0] ql_in;

      if (k == 0) begin : g_head
         assign vld_cur = start_vld;
         assign rem_cur = start_hi;
         assign ql_cur = start_lo;
         assign div_cur = start_div;
         assign side_cur = start_side;
      end else begin : g_tail
         assign vld_cur = vld_ff[k-1];
         assign rem_cur = rem_ff[k-1];
         assign ql_cur = ql_ff[k-1];
         assign div_cur = div_ff[k-1];
         assign side_cur = side_ff[k-1];
      end

      // bring down the next dividend bit and try the subtraction
      assign trial = {rem_cur, ql_cur[QW-1]};
      assign ge = trial >= {1'b0, div_cur};
      assign rem_in = ge ? DW'(trial - {1'b0, div_cur}) : trial[DW-1:0];
      assign ql_in = {ql_cur[QW-2:0], ge};

      always_ff @(posedge clock) begin
         if (reset) begin
            vld_ff[k] <= 1'b0;
         end else if (en) begin
            vld_ff[k] <= vld_cur;
         end
      end

      always_ff @(posedge clock) begin
         if (en) begin
            rem_ff[k] <= rem_in;
            ql_ff[k] <= ql_in;
            div_ff[k] <= div_cur;
            side_ff[k] <= side_cur;
         end
      end
   end

   assign done_vld = vld_ff[QW-1];
   assign done_quo = ql_ff[QW-1];
   assign done_side = side_ff[QW-1];

endmodule

/* hw/rtl/apc_area.sv */
// area below the tangent line of one circle, plus band position of the radius
module apc_area import apc_pkg::*; #(
   parameter int F = 16
) (
   input  logic          clock,
   input  logic          reset,
   input  logic          en,
   input  logic          in_vld,
   input  logic [31:0]   r,
   input  logic [31:0]   y,
   input  logic [F:0]    t,
   input  logic [31:0]   h,
   input  logic [31:0]   radius,
   input  logic [31:0]   side,
   output logic          out_vld,
   output logic [F:0]    area,
   output band_type      band
);

   localparam int AW = F + 4;
   localparam int PW = F + 33;
   localparam int SQW = 2 * F + 2;
   localparam logic [AW-1:0] ONE_A = AW'(1) << F;
   localparam logic [AW-1:0] HALF_A = AW'(1) << (F - 1);
   localparam logic [F:0] ONE_Q = (F+1)'(1) << F;

   typedef struct packed {
      logic       spec;
      logic [F:0] spec_val;
      band_type   band;
      logic       neg;
      logic [31:0] r;
      logic [31:0] y;
      logic [F:0] t;
   } side1_type;

   typedef struct packed {
      logic       spec;
      logic [F:0] spec_val;
      band_type   band;
      logic       neg;
      logic [F:0] t;
   } side2_type;

   typedef struct packed {
      logic          spec;
      logic [F:0]    spec_val;
      band_type      band;
      area_case_type code;
      logic [F:0]    trap;
   } side3_type;

   // entry: band tests, special cases, saturated distance to the circle
   logic [32:0] rph, radph;
   logic [31:0] diff_e, mag_in;
   side1_type   side1_in;
   logic        vld_e_ff;
   logic [31:0] mag_e_ff;
   side1_type   side1_e_ff;

   assign rph = {1'b0, r} + {1'b0, h};
   assign radph = {1'b0, radius} + {1'b0, h};

   always_comb begin
      side1_in.band.near = (rph > {1'b0, radius}) && ({1'b0, r} < radph);
      side1_in.band.above = {1'b0, r} > radph;
      side1_in.band.below = rph < {1'b0, radius};
      side1_in.neg = r < radius;
      side1_in.spec = (y == '0) || (side == '0);
      side1_in.spec_val = ((y == '0) || (r <= radius)) ? ONE_Q : '0;
      side1_in.r = r;
      side1_in.y = y;
      side1_in.t = t;
      diff_e = side1_in.neg ? (radius - r) : (r - radius);
      mag_in = (diff_e > side) ? side : diff_e;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_e_ff <= 1'b0;
      end else if (en) begin
         vld_e_ff <= in_vld;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         mag_e_ff <= mag_in;
         side1_e_ff <= side1_in;
      end
   end

   // q1 = floor(mag * 2^F / side)
   logic       vld_q1;
   logic [F:0] q1;
   side1_type  side1_q1;

   apc_div #(.DW(32), .QW(F + 1), .SW($bits(side1_type))) u_div_q1 (
      .clock      (clock),
      .reset      (reset),
      .en         (en),
      .start_vld  (vld_e_ff),
      .start_hi   ({1'b0, mag_e_ff[31:1]}),
      .start_lo   ({mag_e_ff[0], {F{1'b0}}}),
      .start_div  (side),
      .start_side (side1_e_ff),
      .done_vld   (vld_q1),
      .done_quo   (q1),
      .done_side  (side1_q1)
   );

   // product q1 * r
   logic          vld_p_ff;
   logic [PW-1:0] p_ff;
   logic [31:0]   y_p_ff;
   side2_type     side2_p_ff;
   side2_type     side2_in;

   always_comb begin
      side2_in.spec = side1_q1.spec;
      side2_in.spec_val = side1_q1.spec_val;
      side2_in.band = side1_q1.band;
      side2_in.neg = side1_q1.neg;
      side2_in.t = side1_q1.t;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_p_ff <= 1'b0;
      end else if (en) begin
         vld_p_ff <= vld_q1;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         p_ff <= PW'(q1) * PW'(side1_q1.r);
         y_p_ff <= side1_q1.y;
         side2_p_ff <= side2_in;
      end
   end

   // term = floor(q1 * r / y)
   logic         vld_tm;
   logic [F+1:0] term;
   side2_type    side2_tm;

   apc_div #(.DW(32), .QW(F + 2), .SW($bits(side2_type))) u_div_term (
      .clock      (clock),
      .reset      (reset),
      .en         (en),
      .start_vld  (vld_p_ff),
      .start_hi   ({1'b0, p_ff[F+32:F+2]}),
      .start_lo   (p_ff[F+1:0]),
      .start_div  (y_p_ff),
      .start_side (side2_p_ff),
      .done_vld   (vld_tm),
      .done_quo   (term),
      .done_side  (side2_tm)
   );

   // tangent offset a = 1/2 + t/2 +- term
   logic [AW-1:0]        base_a;
   logic signed [AW-1:0] a_in;
   logic                 vld_a_ff;
   logic signed [AW-1:0] a_ff;
   side2_type            side2_a_ff;

   assign base_a = HALF_A + AW'(side2_tm.t >> 1);
   assign a_in = side2_tm.neg ? $signed(base_a - AW'(term)) : $signed(base_a + AW'(term));

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_a_ff <= 1'b0;
      end else if (en) begin
         vld_a_ff <= vld_tm;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         a_ff <= a_in;
         side2_a_ff <= side2_tm;
      end
   end

   // pick the area case and the value to square
   logic signed [AW-1:0] t_s, lim_s;
   logic [AW-1:0]        trap_w, b_w;
   area_case_type        code_in;
   logic [F:0]           n_in;
   side3_type            side3_in;
   logic                 vld_c_ff;
   logic [F:0]           n_c_ff;
   logic [F:0]           t_c_ff;
   side3_type            side3_c_ff;

   assign t_s = $signed(AW'(side2_a_ff.t));
   assign lim_s = $signed(ONE_A + AW'(side2_a_ff.t));
   assign trap_w = ONE_A + AW'(side2_a_ff.t >> 1) - a_ff;
   assign b_w = ONE_A + AW'(side2_a_ff.t) - a_ff;

   always_comb begin
      if (a_ff[AW-1] || (a_ff == '0)) begin
         code_in = AREA_FULL;
      end else if (a_ff >= lim_s) begin
         code_in = AREA_EMPTY;
      end else if ((a_ff >= t_s) && (a_ff <= $signed(ONE_A))) begin
         code_in = AREA_TRAPEZOID;
      end else if (a_ff < t_s) begin
         code_in = AREA_CORNER;
      end else begin
         code_in = AREA_WEDGE;
      end
      n_in = (code_in == AREA_CORNER) ? a_ff[F:0] : b_w[F:0];
      side3_in.spec = side2_a_ff.spec;
      side3_in.spec_val = side2_a_ff.spec_val;
      side3_in.band = side2_a_ff.band;
      side3_in.code = code_in;
      side3_in.trap = trap_w[F:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_c_ff <= 1'b0;
      end else if (en) begin
         vld_c_ff <= vld_a_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         n_c_ff <= n_in;
         t_c_ff <= side2_a_ff.t;
         side3_c_ff <= side3_in;
      end
   end

   // square of a or b, divisor 2t
   logic           vld_s_ff;
   logic [SQW-1:0] sq_ff;
   logic [F+1:0]   tw_ff;
   side3_type      side3_s_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_s_ff <= 1'b0;
      end else if (en) begin
         vld_s_ff <= vld_c_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         sq_ff <= SQW'(n_c_ff) * SQW'(n_c_ff);
         tw_ff <= {t_c_ff, 1'b0};
         side3_s_ff <= side3_c_ff;
      end
   end

   // floor(n*n / 2t)
   logic         vld_sq;
   logic [F-1:0] quo_sq;
   side3_type    side3_sq;

   apc_div #(.DW(F + 2), .QW(F), .SW($bits(side3_type))) u_div_area (
      .clock      (clock),
      .reset      (reset),
      .en         (en),
      .start_vld  (vld_s_ff),
      .start_hi   (sq_ff[SQW-1:F]),
      .start_lo   (sq_ff[F-1:0]),
      .start_div  (tw_ff),
      .start_side (side3_s_ff),
      .done_vld   (vld_sq),
      .done_quo   (quo_sq),
      .done_side  (side3_sq)
   );

   // final area selection
   logic       vld_f_ff;
   logic [F:0] area_in;
   logic [F:0] area_ff;
   band_type   band_ff;

   always_comb begin
      case (side3_sq.code)
         AREA_FULL:      area_in = ONE_Q;
         AREA_EMPTY:     area_in = '0;
         AREA_TRAPEZOID: area_in = side3_sq.trap;
         AREA_CORNER:    area_in = ONE_Q - {1'b0, quo_sq};
         default:        area_in = {1'b0, quo_sq};
      endcase
      if (side3_sq.spec) begin
         area_in = side3_sq.spec_val;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_f_ff <= 1'b0;
      end else if (en) begin
         vld_f_ff <= vld_sq;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         area_ff <= area_in;
         band_ff <= side3_sq.band;
      end
   end

   assign out_vld = vld_f_ff;
   assign area = area_ff;
   assign band = band_ff;

endmodule

/* hw/rtl/annulus_pixel_coverage_core.sv */
// top level of the annulus pixel coverage pipeline
//
//   port group  direction  contents
//   req_*       in         pixel centre, stream transfer
//   rsp_*       out        coverage fraction, stream transfer
//   csr_*       in/out     inner radius, outer radius, side length
//
// one pixel per cycle enters while the output is not stalled; the latency is set
// by the bit-per-stage square root and the four pipelined dividers on each path.
// reset is synchronous and clears all valid bits; configuration registers take their reset values.
// a result held at rsp stalls the whole pipeline, and req_tready drops with it.
// registers are to be written only while no pixel is in flight; the block itself does not enforce this.
`include "annulus_pixel_coverage_core_assert.svh"

module annulus_pixel_coverage_core import apc_pkg::*; #(
   parameter int FRAC_BITS = 16
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [63:0]           req_tdata,   // center_x [31:0], center_y [63:32]
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [23:0]           rsp_tdata,   // coverage [16:0], zero [23:17]
   input  logic                  csr_psel,
   input  logic                  csr_penable,
   input  logic                  csr_pwrite,
   input  logic [CSR_ADDR_W-1:0] csr_paddr,
   input  logic [31:0]           csr_pwdata,
   output logic [31:0]           csr_prdata,
   output logic                  csr_pready
);

   localparam int F = FRAC_BITS;
   localparam int SR = 32;
   localparam logic [F:0] ONE_Q = (F+1)'(1) << F;
   localparam logic [F+17:0] ROUND_OUT = (F+18)'(1) << (F - 1);

   typedef struct packed {
      logic [31:0] y;
      logic [F:0]  t;
   } yt_type;

   typedef struct packed {
      logic [31:0] x;
      logic [31:0] y;
   } xy_type;

   // configuration registers
   logic        csr_wr;
   logic [1:0]  csr_idx;
   logic [31:0] inner_ff, outer_ff, side_ff;

   assign csr_pready = 1'b1;
   assign csr_wr = csr_psel && csr_penable && csr_pwrite;
   assign csr_idx = csr_paddr[3:2];

   always_ff @(posedge clock) begin
      if (reset) begin
         inner_ff <= '0;
         outer_ff <= '0;
         side_ff <= SIDE_LENGTH_RESET;
      end else if (csr_wr) begin
         unique case (csr_idx)
            REG_INNER_RADIUS: inner_ff <= csr_pwdata;
            REG_OUTER_RADIUS: outer_ff <= csr_pwdata;
            REG_SIDE_LENGTH:  side_ff <= csr_pwdata;
            default: ;
         endcase
      end
   end

   always_comb begin
      unique case (csr_idx)
         REG_INNER_RADIUS: csr_prdata = inner_ff;
         REG_OUTER_RADIUS: csr_prdata = outer_ff;
         REG_SIDE_LENGTH:  csr_prdata = side_ff;
         default:          csr_prdata = '0;
      endcase
   end

   // half diagonal h = round(side / sqrt(2)), follows the register
   logic [63:0] hprod_ff;
   logic [31:0] h_ff;
   logic [63:0] hsum;

   assign hsum = hprod_ff + ROUND_HALF_Q32;

   always_ff @(posedge clock) begin
      hprod_ff <= 64'(side_ff) * 64'(INV_SQRT2_Q32);
      h_ff <= hsum[63:32];
   end

   // global advance: the output register is empty or being drained
   logic rsp_valid_ff;
   logic en;

   assign en = !rsp_valid_ff || rsp_tready;
   assign req_tready = en;

   // fold into the octant 0 <= x <= y
   logic [31:0] ax, ay;
   xy_type      fold_in;
   logic        vld0_ff;
   xy_type      fold_ff;

   assign ax = req_tdata[31] ? (~req_tdata[31:0] + 32'd1) : req_tdata[31:0];
   assign ay = req_tdata[63] ? (~req_tdata[63:32] + 32'd1) : req_tdata[63:32];

   always_comb begin
      if (ay < ax) begin
         fold_in.x = ay;
         fold_in.y = ax;
      end else begin
         fold_in.x = ax;
         fold_in.y = ay;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld0_ff <= 1'b0;
      end else if (en) begin
         vld0_ff <= req_tvalid;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         fold_ff <= fold_in;
      end
   end

   // slope t = floor(x * 2^F / y)
   logic       vld_t;
   logic [F:0] t_q;
   xy_type     xy_t;

   apc_div #(.DW(32), .QW(F + 1), .SW($bits(xy_type))) u_div_slope (
      .clock      (clock),
      .reset      (reset),
      .en         (en),
      .start_vld  (vld0_ff),
      .start_hi   ({1'b0, fold_ff.x[31:1]}),
      .start_lo   ({fold_ff.x[0], {F{1'b0}}}),
      .start_div  (fold_ff.y),
      .start_side (fold_ff),
      .done_vld   (vld_t),
      .done_quo   (t_q),
      .done_side  (xy_t)
   );

   // squares, then their sum
   logic        vld1_ff, vld2_ff;
   logic [63:0] xx_ff, yy_ff, sum_ff;
   yt_type      yt1_ff, yt2_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         vld1_ff <= 1'b0;
         vld2_ff <= 1'b0;
      end else if (en) begin
         vld1_ff <= vld_t;
         vld2_ff <= vld1_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         xx_ff <= 64'(xy_t.x) * 64'(xy_t.x);
         yy_ff <= 64'(xy_t.y) * 64'(xy_t.y);
         yt1_ff <= '{y: xy_t.y, t: t_q};
         sum_ff <= xx_ff + yy_ff;
         yt2_ff <= yt1_ff;
      end
   end

   // integer square root, one root bit per stage
   logic        sq_vld_ff  [SR];
   logic [33:0] sq_rem_ff  [SR];
   logic [31:0] sq_root_ff [SR];
   logic [63:0] sq_v_ff    [SR];
   yt_type      sq_yt_ff   [SR];

   for (genvar k = 0; k < SR; k++) begin : g_sqrt
      logic        vld_cur;
      logic [33:0] rem_cur;
      logic [31:0] root_cur;
      logic [63:0] v_cur;
      yt_type      yt_cur;
      logic [35:0] cur, trial;
      logic        ge;
      logic [33:0] rem_in;

      if (k == 0) begin : g_head
         assign vld_cur = vld2_ff;
         assign rem_cur = '0;
         assign root_cur = '0;
         assign v_cur = sum_ff;
         assign yt_cur = yt2_ff;
      end else begin : g_tail
         assign vld_cur = sq_vld_ff[k-1];
         assign rem_cur = sq_rem_ff[k-1];
         assign root_cur = sq_root_ff[k-1];
         assign v_cur = sq_v_ff[k-1];
         assign yt_cur = sq_yt_ff[k-1];
      end

      assign cur = {rem_cur, v_cur[63:62]};
      assign trial = {2'b00, root_cur, 2'b01};
      assign ge = cur >= trial;
      assign rem_in = ge ? 34'(cur - trial) : cur[33:0];

      always_ff @(posedge clock) begin
         if (reset) begin
            sq_vld_ff[k] <= 1'b0;
         end else if (en) begin
            sq_vld_ff[k] <= vld_cur;
         end
      end

      always_ff @(posedge clock) begin
         if (en) begin
            sq_rem_ff[k] <= rem_in;
            sq_root_ff[k] <= {root_cur[30:0], ge};
            sq_v_ff[k] <= {v_cur[61:0], 2'b00};
            sq_yt_ff[k] <= yt_cur;
         end
      end
   end

   // both circles in parallel
   logic       ain_vld, aout_vld;
   logic [F:0] ain_area, aout_area;
   band_type   ain_band, aout_band;

   apc_area #(.F(F)) u_area_inner (
      .clock   (clock),
      .reset   (reset),
      .en      (en),
      .in_vld  (sq_vld_ff[SR-1]),
      .r       (sq_root_ff[SR-1]),
      .y       (sq_yt_ff[SR-1].y),
      .t       (sq_yt_ff[SR-1].t),
      .h       (h_ff),
      .radius  (inner_ff),
      .side    (side_ff),
      .out_vld (ain_vld),
      .area    (ain_area),
      .band    (ain_band)
   );

   apc_area #(.F(F)) u_area_outer (
      .clock   (clock),
      .reset   (reset),
      .en      (en),
      .in_vld  (sq_vld_ff[SR-1]),
      .r       (sq_root_ff[SR-1]),
      .y       (sq_yt_ff[SR-1].y),
      .t       (sq_yt_ff[SR-1].t),
      .h       (h_ff),
      .radius  (outer_ff),
      .side    (side_ff),
      .out_vld (aout_vld),
      .area    (aout_area),
      .band    (aout_band)
   );

   // band priority and conversion to Q1.16
   logic [F:0]    frac;
   logic [F+17:0] scaled;
   logic [16:0]   cov_in;
   logic [16:0]   cov_ff;

   always_comb begin
      frac = '0;
      if (ain_band.near) begin
         frac = ONE_Q - ain_area;
      end
      if (aout_band.near) begin
         frac = aout_area;
      end
      if (ain_band.above && aout_band.below) begin
         frac = ONE_Q;
      end
      scaled = (F+18)'({frac, 16'b0}) + ROUND_OUT;
      cov_in = scaled[F+16:F];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (en) begin
         rsp_valid_ff <= ain_vld && aout_vld;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         cov_ff <= cov_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata = {7'b0, cov_ff};

   `APC_ASSERT_SAME(a_cov_bound, clock, reset, rsp_valid_ff, cov_ff <= 17'd65536, "coverage above one")
   `APC_ASSERT_NEXT(a_reset_empty, clock, 1'b0, reset, !rsp_valid_ff, "output valid after reset")
   `APC_ASSERT_NEXT(a_stall_hold, clock, reset, rsp_valid_ff && !rsp_tready, rsp_valid_ff && $stable(cov_ff), "stalled result changed")
   `APC_ASSERT_SAME(a_lane_sync, clock, reset, 1'b1, ain_vld == aout_vld, "circle lanes out of step")

endmodule
